FILE: hdl/kmet_pkg.sv
// ----------------------------------------------------------------------------
// kmet_pkg
// Shared types and constants for the key matrix edge tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package kmet_pkg;

  localparam int ROWS      = 8;
  localparam int COLS      = 8;
  localparam int NKEYS     = ROWS * COLS;
  localparam int KEY_IDX_W = $clog2(NKEYS);
  localparam int ROW_IDX_W = $clog2(ROWS);
  localparam int COL_IDX_W = $clog2(COLS);
  localparam int TIME_W    = 32;

  // key status codes
  localparam logic [1:0] ST_NONE = 2'd0;
  localparam logic [1:0] ST_RISE = 2'd1;
  localparam logic [1:0] ST_HELD = 2'd2;
  localparam logic [1:0] ST_FALL = 2'd3;

  typedef struct packed {
    logic [2:0]        key_row;
    logic [2:0]        key_col;
    logic              key_level;
    logic [TIME_W-1:0] time_ms;
  } kmet_in_t;

  typedef struct packed {
    logic [1:0]        key_status;
    logic [TIME_W-1:0] press_duration_ms;
    logic              rising_found;
    logic [2:0]        rising_row;
    logic [2:0]        rising_col;
  } kmet_out_t;

  // sample sitting in the update stage
  typedef struct packed {
    logic                 valid;
    logic                 in_range;
    logic [KEY_IDX_W-1:0] idx;
    logic                 level;
    logic [TIME_W-1:0]    time_ms;
  } kmet_stage_t;

endpackage

`default_nettype wire

FILE: hdl/key_matrix_edge_tracker_core.sv
// A result strobes on done after the update stage (s1) and the output register.
// Throughput: one sample per cycle; busy is never raised.
// The press-start memory is read at the start transfer and written back in the
// cycle after it, with a bypass for back-to-back samples of the same key.
// Reset clears all key-down flags and the rising mask at once; no clearing
// pass. The receiver cannot stall; each result shows for one cycle.
// ----------------------------------------------------------------------------
// key_matrix_edge_tracker_core
// Edge and hold tracker for a sampled key matrix.
// ----------------------------------------------------------------------------
`default_nettype none

module key_matrix_edge_tracker_core
  import kmet_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  kmet_in_t  item,
  output logic      done,
  output kmet_out_t result
);

  logic                 accept;
  logic [KEY_IDX_W-1:0] in_idx;
  logic                 in_range;
  kmet_stage_t          s1;
  kmet_out_t            res_next;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign in_range = (int'(item.key_row) < ROWS) && (int'(item.key_col) < COLS);
  assign in_idx   = KEY_IDX_W'(int'(item.key_row) * COLS + int'(item.key_col));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1.valid <= accept;
      done     <= s1.valid;
    end
    s1.in_range <= in_range;
    s1.idx      <= in_idx;
    s1.level    <= item.key_level;
    s1.time_ms  <= item.time_ms;
    result      <= res_next;
  end

  kmet_tracker u_track (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept),
    .rd_idx (in_idx),
    .s1     (s1),
    .res    (res_next)
  );

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> ##1 done)
    else $error("missing done after transfer");

  a_dur_edges: assert property (@(posedge clk) disable iff (rst)
    done && (result.key_status != ST_HELD) |-> (result.press_duration_ms == '0))
    else $error("nonzero duration outside held status");

  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.rising_found |-> (result.rising_row == 3'd0) &&
      (result.rising_col == 3'd0))
    else $error("rising position set without a rising key");

  a_rise_found: assert property (@(posedge clk) disable iff (rst)
    done && (result.key_status == ST_RISE) |-> result.rising_found)
    else $error("rising edge not reflected in mask");

endmodule

`default_nettype wire

FILE: hdl/kmet_first_enc.sv
// ----------------------------------------------------------------------------
// kmet_first_enc
// Finds the first set bit of the rising mask in row-major order.
// ----------------------------------------------------------------------------
`default_nettype none

module kmet_first_enc
  import kmet_pkg::*;
(
  input  logic [NKEYS-1:0] mask,
  output logic             found,
  output logic [2:0]       first_row,
  output logic [2:0]       first_col
);

  logic [ROWS-1:0]      row_any;
  logic [COLS-1:0]      row_bits;
  logic [ROW_IDX_W-1:0] sel_r;
  logic [COL_IDX_W-1:0] sel_c;

  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      row_any[r] = |mask[r*COLS +: COLS];
    end
  end

  // two small priority picks: row first, then column inside that row
  always_comb begin
    sel_r = '0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (row_any[r]) sel_r = ROW_IDX_W'(r);
    end
    row_bits = mask[int'(sel_r)*COLS +: COLS];
    sel_c = '0;
    for (int c = COLS - 1; c >= 0; c--) begin
      if (row_bits[c]) sel_c = COL_IDX_W'(c);
    end
  end

  assign found     = |row_any;
  assign first_row = found ? 3'(sel_r) : 3'd0;
  assign first_col = found ? 3'(sel_c) : 3'd0;

endmodule

`default_nettype wire

FILE: hdl/kmet_tracker.sv
// ----------------------------------------------------------------------------
// kmet_tracker
// Per-key state: down flags, rising mask and press-start memory. Computes
// the result for the sample in the update stage.
// ----------------------------------------------------------------------------
`default_nettype none

module kmet_tracker
  import kmet_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rd_en,
  input  logic [KEY_IDX_W-1:0] rd_idx,
  input  kmet_stage_t          s1,
  output kmet_out_t            res
);

  logic [TIME_W-1:0] press_mem [NKEYS];
  logic [TIME_W-1:0] rd_data;
  logic [NKEYS-1:0]  key_down;
  logic [NKEYS-1:0]  rising_mask;
  logic [NKEYS-1:0]  rising_mask_next;
  logic              upd;
  logic              down;
  logic              is_rise;
  logic              is_held;
  logic              is_fall;
  logic              found;
  logic [2:0]        first_row;
  logic [2:0]        first_col;

  assign upd     = s1.valid && s1.in_range;
  assign down    = key_down[s1.idx];
  assign is_rise = upd && s1.level && !down;
  assign is_held = upd && s1.level && down;
  assign is_fall = upd && !s1.level && down;

  // start time is only read while the key is down, so the cleared value on
  // release never needs storing
  always_ff @(posedge clk) begin
    if (is_rise) press_mem[s1.idx] <= s1.time_ms;
    if (rd_en) begin
      if (is_rise && (s1.idx == rd_idx)) rd_data <= s1.time_ms;
      else rd_data <= press_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_down    <= '0;
      rising_mask <= '0;
    end else begin
      if (upd) key_down[s1.idx] <= s1.level;
      rising_mask <= rising_mask_next;
    end
  end

  always_comb begin
    rising_mask_next = rising_mask;
    if (upd) rising_mask_next[s1.idx] = is_rise;
  end

  kmet_first_enc u_enc (
    .mask      (rising_mask_next),
    .found     (found),
    .first_row (first_row),
    .first_col (first_col)
  );

  always_comb begin
    res = '0;
    if (is_rise)      res.key_status = ST_RISE;
    else if (is_held) res.key_status = ST_HELD;
    else if (is_fall) res.key_status = ST_FALL;
    else              res.key_status = ST_NONE;
    res.press_duration_ms = is_held ? (s1.time_ms - rd_data) : '0;
    res.rising_found      = found;
    res.rising_row        = first_row;
    res.rising_col        = first_col;
  end

endmodule

`default_nettype wire
